[rtl/tpbn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbn_pkg
// shared types, constants and the tone sequence table of the pinyin
// byte normalizer
// ----------------------------------------------------------------------------
package tpbn_pkg;

    localparam int BYTE_W      = 8;
    localparam int LETTER_W    = 7;
    localparam int LENGTH_W    = 10;
    localparam int STATUS_W    = 2;
    localparam int CAP_W       = 11;
    localparam int TAB_DEPTH   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int MAX_CAPACITY_DEFAULT = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd64;

    // end report status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAPACITY = 2'd2;

    localparam logic [BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_Z = 8'h7A;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic                is_end;
        logic [LETTER_W-1:0] letter;
        logic [LENGTH_W-1:0] length;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // one queue entry: the results that one input byte causes
    typedef struct packed {
        logic                has_letter;
        logic [LETTER_W-1:0] letter;
        logic                has_end;
        logic [LENGTH_W-1:0] length;
        logic [STATUS_W-1:0] status;
    } entry_t;

    typedef struct packed {
        logic         push;
        entry_t       entry;
    } push_t;

    typedef struct packed {
        logic         full;
        logic         empty;
    } q_status_t;

    typedef struct packed {
        logic [1:0]          n;
        logic [BYTE_W-1:0]   b0;
        logic [BYTE_W-1:0]   b1;
        logic [BYTE_W-1:0]   b2;
        logic [LETTER_W-1:0] plain;
    } tone_entry_t;

    typedef struct packed {
        logic [LETTER_W-1:0] plain;
        logic                partial;
    } match_t;

    localparam tone_entry_t TONE_TAB [TAB_DEPTH] = '{
        '{2'd2, 8'hC4, 8'h81, 8'h00, 7'h61}, '{2'd2, 8'hC3, 8'hA1, 8'h00, 7'h61},
        '{2'd2, 8'hC7, 8'h8E, 8'h00, 7'h61}, '{2'd2, 8'hC3, 8'hA0, 8'h00, 7'h61},
        '{2'd2, 8'hC4, 8'h93, 8'h00, 7'h65}, '{2'd2, 8'hC3, 8'hA9, 8'h00, 7'h65},
        '{2'd2, 8'hC4, 8'h9B, 8'h00, 7'h65}, '{2'd2, 8'hC3, 8'hA8, 8'h00, 7'h65},
        '{2'd2, 8'hC4, 8'hAB, 8'h00, 7'h69}, '{2'd2, 8'hC3, 8'hAD, 8'h00, 7'h69},
        '{2'd2, 8'hC7, 8'h90, 8'h00, 7'h69}, '{2'd2, 8'hC3, 8'hAC, 8'h00, 7'h69},
        '{2'd2, 8'hC5, 8'h8D, 8'h00, 7'h6F}, '{2'd2, 8'hC3, 8'hB3, 8'h00, 7'h6F},
        '{2'd2, 8'hC7, 8'h92, 8'h00, 7'h6F}, '{2'd2, 8'hC3, 8'hB2, 8'h00, 7'h6F},
        '{2'd2, 8'hC5, 8'hAB, 8'h00, 7'h75}, '{2'd2, 8'hC3, 8'hBA, 8'h00, 7'h75},
        '{2'd2, 8'hC7, 8'h94, 8'h00, 7'h75}, '{2'd2, 8'hC3, 8'hB9, 8'h00, 7'h75},
        '{2'd2, 8'hC7, 8'h96, 8'h00, 7'h76}, '{2'd2, 8'hC7, 8'h98, 8'h00, 7'h76},
        '{2'd2, 8'hC7, 8'h9A, 8'h00, 7'h76}, '{2'd2, 8'hC7, 8'h9C, 8'h00, 7'h76},
        '{2'd2, 8'hC3, 8'hBC, 8'h00, 7'h76}, '{2'd2, 8'hC5, 8'h84, 8'h00, 7'h6E},
        '{2'd2, 8'hC5, 8'h88, 8'h00, 7'h6E}, '{2'd2, 8'hC7, 8'hB9, 8'h00, 7'h6E},
        '{2'd3, 8'hE1, 8'hB8, 8'hBF, 7'h6D}, '{2'd2, 8'hC3, 8'hAA, 8'h00, 7'h65},
        '{2'd3, 8'hE1, 8'hBA, 8'hBF, 7'h65}, '{2'd3, 8'hE1, 8'hBB, 8'h81, 7'h65}
    };

    // parallel compare of the first k bytes against every table entry
    function automatic match_t tone_match(
        input logic [1:0]        k,
        input logic [BYTE_W-1:0] s0,
        input logic [BYTE_W-1:0] s1,
        input logic [BYTE_W-1:0] s2
    );
        match_t res;
        logic   hit;
        res = '0;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            hit = (TONE_TAB[i].n >= k) && (TONE_TAB[i].b0 == s0);
            if (k >= 2'd2 && TONE_TAB[i].b1 != s1)
                hit = 1'b0;
            if (k >= 2'd3 && TONE_TAB[i].b2 != s2)
                hit = 1'b0;
            if (hit) begin
                if (TONE_TAB[i].n == k) begin
                    if (res.plain == '0)
                        res.plain = TONE_TAB[i].plain;
                end
                else begin
                    res.partial = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

[rtl/tpbn_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbn_front
// accepts bytes, tracks the open utf-8 sequence, letter count and error,
// and queues the results of each byte
// ----------------------------------------------------------------------------
module tpbn_front #(
    parameter int MAX_CAPACITY = tpbn_pkg::MAX_CAPACITY_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [tpbn_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    input  tpbn_pkg::in_item_t        in_data,
    input  tpbn_pkg::q_status_t       q_stat,
    output tpbn_pkg::push_t           q_push
);
    import tpbn_pkg::*;

    localparam int CNT_W  = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
    localparam int MAXV_W = $clog2(MAX_CAPACITY + 1);
    localparam int CMP_W  = ((MAXV_W > CAP_W) ? MAXV_W : CAP_W) + 1;

    logic [CAP_W-1:0]    cap_reg;
    logic [15:0]         pbytes_reg, pbytes_next;
    logic [1:0]          pcount_reg, pcount_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    logic                accept;
    logic [BYTE_W-1:0]   b;
    logic [LETTER_W-1:0] plain;
    match_t              m;
    logic [1:0]          k;
    logic [BYTE_W-1:0]   s0, s1, s2;
    logic [CMP_W-1:0]    cap_ext, max_ext, limit, cnt_inc;
    logic [STATUS_W-1:0] err_fin;
    logic [CNT_W+LENGTH_W-1:0] cnt_wide;
    entry_t              e;

    assign accept = in_valid && !q_stat.full;
    assign b      = in_data.in_byte;

    // sequence bytes seen so far plus the new one
    assign k  = pcount_reg + 2'd1;
    assign s0 = (pcount_reg == 2'd0) ? b : pbytes_reg[7:0];
    assign s1 = (pcount_reg == 2'd1) ? b : pbytes_reg[15:8];
    assign s2 = (pcount_reg == 2'd2) ? b : 8'h00;
    assign m  = tone_match(k, s0, s1, s2);

    assign cap_ext = CMP_W'(cap_reg);
    assign max_ext = CMP_W'(MAX_CAPACITY);
    assign limit   = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign cnt_inc = CMP_W'(cnt_reg) + CMP_W'(1);

    always_comb
    begin
        pbytes_next = pbytes_reg;
        pcount_next = pcount_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        plain       = '0;
        e           = '0;

        if (err_reg == ST_OK) begin
            if (pcount_reg == 2'd0 && !b[7]) begin
                if (b >= CH_A && b <= CH_Z)
                    plain = b[LETTER_W-1:0];
                else
                    err_next = ST_UNKNOWN;
            end
            else if (m.plain != '0) begin
                plain       = m.plain;
                pbytes_next = '0;
                pcount_next = 2'd0;
            end
            else if (m.partial) begin
                pbytes_next = (pcount_reg == 2'd0) ? {8'h00, b} : {b, pbytes_reg[7:0]};
                pcount_next = pcount_reg + 2'd1;
            end
            else begin
                pbytes_next = '0;
                pcount_next = 2'd0;
                err_next    = ST_UNKNOWN;
            end

            if (plain != '0) begin
                if (cnt_inc >= limit) begin
                    err_next = ST_CAPACITY;
                end
                else begin
                    e.has_letter = 1'b1;
                    e.letter     = plain;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
        end

        // end report, truncated sequence counts as unknown
        err_fin  = (err_next == ST_OK && pcount_next != 2'd0) ? ST_UNKNOWN : err_next;
        cnt_wide = {{LENGTH_W{1'b0}}, cnt_next};
        if (in_data.in_last) begin
            e.has_end   = 1'b1;
            e.status    = err_fin;
            e.length    = (err_fin == ST_OK) ? cnt_wide[LENGTH_W-1:0] : '0;
            pbytes_next = '0;
            pcount_next = 2'd0;
            cnt_next    = '0;
            err_next    = ST_OK;
        end
    end

    assign q_push.push  = accept && (e.has_letter || e.has_end);
    assign q_push.entry = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg    <= CAP_RESET;
            pbytes_reg <= '0;
            pcount_reg <= 2'd0;
            cnt_reg    <= '0;
            err_reg    <= ST_OK;
        end
        else begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (accept) begin
                pbytes_reg <= pbytes_next;
                pcount_reg <= pcount_next;
                cnt_reg    <= cnt_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

[rtl/tpbn_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbn_queue
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
module tpbn_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  tpbn_pkg::push_t     q_push,
    input  logic                pop,
    output tpbn_pkg::q_status_t q_stat,
    output tpbn_pkg::entry_t    head
);
    import tpbn_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (q_push.push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!q_push.push && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
            mem_reg[wr_ptr_reg] <= q_push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (q_push.push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

[rtl/tpbn_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbn_back
// turns queue entries into result transfers, letter first then end report
// ----------------------------------------------------------------------------
module tpbn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tpbn_pkg::q_status_t q_stat,
    input  tpbn_pkg::entry_t    head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output tpbn_pkg::out_item_t out_data
);
    import tpbn_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      done_reg, done_next;
    logic      load;

    always_comb
    begin
        pop            = 1'b0;
        load           = !q_stat.empty && (!out_valid_reg || !out_stall);
        done_next      = done_reg;
        out_data_next  = '0;
        out_valid_next = out_valid_reg && out_stall;

        if (load) begin
            out_valid_next = 1'b1;
            if (head.has_letter && !done_reg) begin
                out_data_next.letter = head.letter;
                if (head.has_end)
                    done_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else begin
                out_data_next.is_end = 1'b1;
                out_data_next.length = head.length;
                out_data_next.status = head.status;
                pop                  = 1'b1;
                done_next            = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/toned_pinyin_byte_normalizer_core.sv]
`timescale 1ns / 1ps
// path: a result is written into the queue at its byte transfer, then into the
//   output register, from which it is presented on the output channel
// throughput: one byte per cycle while the queue is not full; a byte that gives a
//   letter and an end report holds the single output register for both in turn
// reset: string state clears, capacity register returns to 64, queue empties
// ----------------------------------------------------------------------------
// toned_pinyin_byte_normalizer_core
// normalizes a utf-8 toned pinyin byte stream to plain ascii letters
// ----------------------------------------------------------------------------
module toned_pinyin_byte_normalizer_core #(
    parameter int MAX_CAPACITY = tpbn_pkg::MAX_CAPACITY_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // capacity register write
    input  logic                       cfg_wr_en,
    input  logic [tpbn_pkg::CAP_W-1:0] cfg_wr_data,
    // byte input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  tpbn_pkg::in_item_t         in_data,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output tpbn_pkg::out_item_t        out_data
);
    import tpbn_pkg::*;

    push_t     q_push;
    q_status_t q_stat;
    entry_t    q_head;
    logic      q_pop;

    // front stalls only when the queue is full
    assign in_stall = q_stat.full;

    // front: decode and state tracking, one byte per transfer
    tpbn_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .q_stat      (q_stat),
        .q_push      (q_push)
    );

    // queue decouples front from a stalled output
    tpbn_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .q_stat (q_stat),
        .head   (q_head)
    );

    // back: splits each entry into letter and end report transfers
    tpbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[dv/toned_pinyin_byte_normalizer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toned_pinyin_byte_normalizer_core_tb
// self-checking bench: utf-8 pinyin strings go in one byte per transfer, a
// cycle-free predictor computes the letters and end reports each byte should
// give, and every result transfer is compared field by field in order
// ----------------------------------------------------------------------------
module toned_pinyin_byte_normalizer_core_tb;

    import tpbn_pkg::*;

    localparam int          MAX_CAP     = MAX_CAPACITY_DEFAULT;
    localparam int          DRAIN_WAIT  = 8;       // quiet cycles in a row before idle
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          REPORT_MAX  = 10;
    localparam logic [7:0]  LEAD_MIN    = 8'h80;   // first non-ascii byte

    // toned vowel table: {b0, b1, b2, plain letter}; b2 of 0 marks a 2-byte entry
    localparam logic [31:0] TONE_SEQS [32] = '{
        32'hC4_81_00_61, 32'hC3_A1_00_61, 32'hC7_8E_00_61, 32'hC3_A0_00_61,
        32'hC4_93_00_65, 32'hC3_A9_00_65, 32'hC4_9B_00_65, 32'hC3_A8_00_65,
        32'hC4_AB_00_69, 32'hC3_AD_00_69, 32'hC7_90_00_69, 32'hC3_AC_00_69,
        32'hC5_8D_00_6F, 32'hC3_B3_00_6F, 32'hC7_92_00_6F, 32'hC3_B2_00_6F,
        32'hC5_AB_00_75, 32'hC3_BA_00_75, 32'hC7_94_00_75, 32'hC3_B9_00_75,
        32'hC7_96_00_76, 32'hC7_98_00_76, 32'hC7_9A_00_76, 32'hC7_9C_00_76,
        32'hC3_BC_00_76, 32'hC5_84_00_6E, 32'hC5_88_00_6E, 32'hC7_B9_00_6E,
        32'hE1_B8_BF_6D, 32'hC3_AA_00_65, 32'hE1_BA_BF_65, 32'hE1_BB_81_65
    };

    // dut ports, all inputs known from time zero
    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    in_item_t         in_data     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    out_item_t        out_data;

    // stimulus and scoreboard
    in_item_t         byte_queue [$];
    out_item_t        expected_results [$];
    out_item_t        want_item;
    logic             byte_taken   = 1'b0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               failures     = 0;
    int               cycles       = 0;

    // predictor copy of the block state
    logic [CAP_W-1:0] capacity_reg = CAP_RESET;
    logic [7:0]       seq_b0       = '0;
    logic [7:0]       seq_b1       = '0;
    int               seq_len      = 0;
    int               letters_out  = 0;
    logic [1:0]       string_err   = ST_OK;

    toned_pinyin_byte_normalizer_core #(
        .MAX_CAPACITY (MAX_CAP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // returns {partial, plain}: plain is nonzero when the first k bytes
    // complete an entry, partial when they are a proper prefix of one
    function automatic logic [7:0] tone_lookup(input int k, input logic [7:0] s0,
                                               input logic [7:0] s1, input logic [7:0] s2);
        logic [6:0] plain;
        logic       partial;
        logic       hit;
        int         n;
        plain   = '0;
        partial = 1'b0;
        for (int i = 0; i < 32; i++)
        begin
            n   = (TONE_SEQS[i][15:8] != 8'h00) ? 3 : 2;
            hit = (n >= k) && (TONE_SEQS[i][31:24] == s0);
            if (k >= 2 && TONE_SEQS[i][23:16] != s1)
                hit = 1'b0;
            if (k >= 3 && TONE_SEQS[i][15:8] != s2)
                hit = 1'b0;
            if (hit && n == k && plain == '0)
                plain = TONE_SEQS[i][6:0];
            else if (hit && n != k)
                partial = 1'b1;
        end
        return {partial, plain};
    endfunction

    // advance the string state by one accepted byte, queue what it yields
    task automatic normalize_byte(input in_item_t item);
        logic [7:0] b;
        logic [7:0] found;
        logic [6:0] plain;
        int         limit;
        out_item_t  res;
        b     = item.in_byte;
        plain = '0;
        if (string_err == ST_OK)
        begin
            if (seq_len == 0 && b < LEAD_MIN)
            begin
                // plain ascii outside a sequence
                if (b >= CH_A && b <= CH_Z)
                    plain = b[6:0];
                else
                    string_err = ST_UNKNOWN;
            end
            else
            begin
                // the new byte lands at position seq_len of the open sequence
                found = tone_lookup(seq_len + 1,
                                    (seq_len == 0) ? b : seq_b0,
                                    (seq_len == 1) ? b : seq_b1,
                                    (seq_len == 2) ? b : 8'h00);
                plain = found[6:0];
                if (plain != '0)
                begin
                    seq_b0  = '0;
                    seq_b1  = '0;
                    seq_len = 0;
                end
                else if (found[7])
                begin
                    if (seq_len == 0)
                        seq_b0 = b;
                    else
                        seq_b1 = b;
                    seq_len++;
                end
                else
                begin
                    // broken sequence
                    seq_b0     = '0;
                    seq_b1     = '0;
                    seq_len    = 0;
                    string_err = ST_UNKNOWN;
                end
            end
            if (plain != '0)
            begin
                // oversized capacity values saturate at the block maximum
                limit = (int'(capacity_reg) > MAX_CAP) ? MAX_CAP : int'(capacity_reg);
                if (letters_out + 1 >= limit)
                    string_err = ST_CAPACITY;
                else
                begin
                    res.is_end = 1'b0;
                    res.letter = plain;
                    res.length = '0;
                    res.status = ST_OK;
                    expected_results.push_back(res);
                    letters_out++;
                end
            end
        end
        if (item.in_last)
        begin
            // an open sequence at the end counts as truncated
            if (string_err == ST_OK && seq_len != 0)
                string_err = ST_UNKNOWN;
            res.is_end = 1'b1;
            res.letter = '0;
            res.length = (string_err == ST_OK) ? LENGTH_W'(letters_out) : '0;
            res.status = string_err;
            expected_results.push_back(res);
            seq_b0      = '0;
            seq_b1      = '0;
            seq_len     = 0;
            letters_out = 0;
            string_err  = ST_OK;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: byte channel and result-side stall, all changes at falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            // a held byte stays put until its transfer completes
            if (!in_valid || byte_taken)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_data  <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both transfers are sampled at the rising edge
    // ------------------------------------------------------------------------
    task automatic report_failure(input string what, input out_item_t want,
                                  input out_item_t got);
        failures++;
        if (failures <= REPORT_MAX)
        begin
            $display("mismatch (%s) at cycle %0d: expected end=%0d letter=%h len=%0d st=%0d",
                     what, cycles, want.is_end, want.letter, want.length, want.status);
            $display("    got end=%0d letter=%h len=%0d st=%0d",
                     got.is_end, got.letter, got.length, got.status);
        end
    endtask

    always @(posedge clk)
    begin
        byte_taken <= in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_failure("unexpected result", '0, out_data);
            end
            else
            begin
                want_item = expected_results.pop_front();
                if (out_data.is_end !== want_item.is_end ||
                    out_data.letter !== want_item.letter ||
                    out_data.length !== want_item.length ||
                    out_data.status !== want_item.status)
                    report_failure("wrong field", want_item, out_data);
            end
        end
        // prediction of a byte transfer can never be due at this same edge
        if (rst_n && in_valid && !in_stall)
            normalize_byte(in_data);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last);
        in_item_t item;
        item.in_byte = b;
        item.in_last = last;
        byte_queue.push_back(item);
    endtask

    // sender holds off until the block is idle: no queued or held byte and
    // every result back, for several falling edges in a row
    task automatic drain();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_WAIT)
        begin
            @(negedge clk);
            if (byte_queue.size() > 0 || in_valid || expected_results.size() > 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // capacity writes only happen with the block idle
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = cap;
    endtask

    // random strings, mostly well-formed letters and tone sequences with
    // some noise: stray bytes, non-letter ascii, cut-off sequences
    task automatic queue_strings(input int n_bytes, input int max_units);
        int         total;
        int         units;
        int         pick;
        int         sel;
        logic [7:0] seq [$];
        total = 0;
        while (total < n_bytes)
        begin
            units = $urandom_range(max_units, 1);
            seq.delete();
            for (int u = 0; u < units; u++)
            begin
                pick = $urandom_range(99, 0);
                sel  = $urandom_range(31, 0);
                if (pick < 45)
                    seq.push_back(8'(CH_A + $urandom_range(25, 0)));
                else if (pick < 90)
                begin
                    seq.push_back(TONE_SEQS[sel][31:24]);
                    seq.push_back(TONE_SEQS[sel][23:16]);
                    if (TONE_SEQS[sel][15:8] != 8'h00)
                        seq.push_back(TONE_SEQS[sel][15:8]);
                end
                else if (pick < 94)
                    seq.push_back(8'($urandom_range(255, 0)));
                else if (pick < 97)
                    seq.push_back(8'($urandom_range(CH_A - 1, 0)));
                else
                begin
                    // cut-off sequence: lead byte, maybe one continuation
                    seq.push_back(TONE_SEQS[sel][31:24]);
                    if (TONE_SEQS[sel][15:8] != 8'h00 && $urandom_range(1, 0) == 1)
                        seq.push_back(TONE_SEQS[sel][23:16]);
                end
            end
            foreach (seq[i])
                push_byte(seq[i], i == seq.size() - 1);
            total += seq.size();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed strings at the reset capacity, no idling
        push_byte(CH_A, 1'b1);                 // single letter, two results
        push_byte(CH_Z, 1'b0);                 // letter then the zero byte
        push_byte(8'h00, 1'b1);
        push_byte(CH_A - 8'd1, 1'b1);          // just below a
        push_byte(CH_Z + 8'd1, 1'b1);          // just above z
        push_byte(8'h7F, 1'b1);
        push_byte(8'hC4, 1'b0);                // a macron
        push_byte(8'h81, 1'b0);
        push_byte(8'hE1, 1'b0);                // m acute, 3 bytes
        push_byte(8'hB8, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hC3, 1'b0);                // u umlaut maps to v
        push_byte(8'hBC, 1'b0);
        push_byte(8'hE1, 1'b0);                // e circumflex grave, ends string
        push_byte(8'hBB, 1'b0);
        push_byte(8'h81, 1'b1);
        push_byte(8'hC4, 1'b1);                // truncated at the end
        push_byte(8'hC4, 1'b0);                // ascii inside a sequence
        push_byte(CH_A, 1'b1);
        push_byte(LEAD_MIN, 1'b0);             // lead byte that starts nothing
        push_byte(CH_A, 1'b1);                 // silenced after the error
        push_byte(8'hFF, 1'b1);
        push_byte(8'hE1, 1'b0);                // broken at the third byte
        push_byte(8'hB8, 1'b0);
        push_byte(8'hC4, 1'b0);
        push_byte(8'h81, 1'b1);

        // oversized capacity acts as the maximum: a 1024-letter string
        // overflows on its last letter
        set_capacity(11'd2047);
        for (int i = 0; i < 1024; i++)
            push_byte(8'(CH_A + $urandom_range(25, 0)), i == 1023);
        queue_strings(40, 8);

        set_capacity(11'd0);                   // every letter fails
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        queue_strings(50, 4);

        set_capacity(11'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        queue_strings(50, 4);

        set_capacity(11'd2);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        queue_strings(50, 6);

        set_capacity(11'd5);
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        queue_strings(50, 8);

        set_capacity(11'd1024);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        queue_strings(60, 12);

        set_capacity(CAP_RESET);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        queue_strings(60, 12);

        set_capacity(11'd1000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_strings(40, 8);

        drain();
        if (failures == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/tpbn_pkg.sv
rtl/tpbn_front.sv
rtl/tpbn_queue.sv
rtl/tpbn_back.sv
rtl/toned_pinyin_byte_normalizer_core.sv
dv/toned_pinyin_byte_normalizer_core_tb.sv
